[rtl/fvdu_pkg.sv]
// Shared types, constants and single-precision arithmetic functions for the
// float vector DSP unit. No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package fvdu_pkg;

  localparam int LANES       = 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LEN_W       = 16;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;

  typedef enum logic [2:0] {
    OP_MUL        = 3'd0,
    OP_MUL_SCALAR = 3'd1,
    OP_MAC_SCALAR = 3'd2,
    OP_MUL_ADD    = 3'd3,
    OP_DOT        = 3'd4,
    OP_BUTTERFLY  = 3'd5
  } op_t;

  typedef enum logic [0:0] {
    CFG_SCALAR_FACTOR = 1'b0,
    CFG_VECTOR_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] addend;
  } in_item_t;

  typedef struct packed {
    logic [31:0] first_result;
    logic [31:0] second_result;
    logic        is_dot_total;
  } out_item_t;

  // Where a dot product element falls within its vector.
  typedef struct packed {
    logic              last_full;
    logic              in_tail;
    logic              is_last;
    logic [LANE_W-1:0] lane;
  } dot_tag_t;

  // Classified work item; b already holds the scalar for scalar commands.
  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    dot_tag_t    tag;
  } work_t;

  // Single-precision multiply, round to nearest even, canonical NaN.
  function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
    logic               sr;
    logic [7:0]         ex, ey, exe, eye, expf;
    logic               xnan, ynan, xinf, yinf, xzero, yzero;
    logic [23:0]        mx, my, m;
    logic [47:0]        p, pn, pd;
    logic [5:0]         lz;
    logic signed [10:0] er;
    logic [7:0]         sh;
    logic               st, g, s, up;
    logic [31:0]        r;
    sr    = x[31] ^ y[31];
    ex    = x[30:23];
    ey    = y[30:23];
    xnan  = (ex == 8'hFF) && (x[22:0] != 23'd0);
    ynan  = (ey == 8'hFF) && (y[22:0] != 23'd0);
    xinf  = (ex == 8'hFF) && (x[22:0] == 23'd0);
    yinf  = (ey == 8'hFF) && (y[22:0] == 23'd0);
    xzero = (ex == 8'h00) && (x[22:0] == 23'd0);
    yzero = (ey == 8'h00) && (y[22:0] == 23'd0);
    exe   = (ex == 8'h00) ? 8'd1 : ex;
    eye   = (ey == 8'h00) ? 8'd1 : ey;
    mx    = {ex != 8'h00, x[22:0]};
    my    = {ey != 8'h00, y[22:0]};
    p     = mx * my;
    lz    = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    pn = p << lz;
    er = $signed({3'b000, exe}) + $signed({3'b000, eye}) - 11'sd126
         - $signed({5'b00000, lz});
    if (er <= 11'sd0) begin
      sh   = 8'(11'sd1 - er);
      pd   = pn >> sh;
      st   = |(pn & ~(48'hFFFF_FFFF_FFFF << sh));
      expf = 8'd0;
    end else begin
      pd   = pn;
      st   = 1'b0;
      expf = er[7:0];
    end
    m  = pd[47:24];
    g  = pd[23];
    s  = (|pd[22:0]) | st;
    up = g & (s | m[0]);
    r  = {sr, expf, m[22:0]} + {31'd0, up};
    if (xnan || ynan) begin
      r = FP_QNAN;
    end else if (xinf || yinf) begin
      r = (xzero || yzero) ? FP_QNAN : {sr, 8'hFF, 23'd0};
    end else if (xzero || yzero) begin
      r = {sr, 31'd0};
    end else if (er >= 11'sd255) begin
      r = {sr, 8'hFF, 23'd0};
    end
    return r;
  endfunction

  // Single-precision add, round to nearest even, canonical NaN.
  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic        xnan, ynan, xinf, yinf, swap, sb, up, g, s, st;
    logic [7:0]  ex, ey, e1, e2, d, expf, sh;
    logic [23:0] m1, m2, m;
    logic [26:0] ax, bx, al, r27;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic [8:0]  ee;
    logic [31:0] r;
    ex   = x[30:23];
    ey   = y[30:23];
    xnan = (ex == 8'hFF) && (x[22:0] != 23'd0);
    ynan = (ey == 8'hFF) && (y[22:0] != 23'd0);
    xinf = (ex == 8'hFF) && (x[22:0] == 23'd0);
    yinf = (ey == 8'hFF) && (y[22:0] == 23'd0);
    swap = y[30:0] > x[30:0];
    sb   = swap ? y[31] : x[31];
    e1   = swap ? ey : ex;
    e2   = swap ? ex : ey;
    m1   = swap ? {ey != 8'h00, y[22:0]} : {ex != 8'h00, x[22:0]};
    m2   = swap ? {ex != 8'h00, x[22:0]} : {ey != 8'h00, y[22:0]};
    if (e1 == 8'h00) e1 = 8'd1;
    if (e2 == 8'h00) e2 = 8'd1;
    d  = e1 - e2;
    ax = {m1, 3'b000};
    bx = {m2, 3'b000};
    al = bx >> d;
    st = |(bx & ~(27'h7FF_FFFF << d));
    al[0] = al[0] | st;
    if (x[31] == y[31]) sum = {1'b0, ax} + {1'b0, al};
    else                sum = {1'b0, ax} - {1'b0, al};
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz = 5'(26 - i);
    end
    if (sum[27]) begin
      r27 = sum[27:1] | {26'd0, sum[0]};
      ee  = {1'b0, e1} + 9'd1;
    end else begin
      sh  = ({3'b000, lz} < (e1 - 8'd1)) ? {3'b000, lz} : (e1 - 8'd1);
      r27 = sum[26:0] << sh;
      ee  = {1'b0, e1} - {1'b0, sh};
    end
    expf = r27[26] ? ee[7:0] : 8'd0;
    m    = r27[26:3];
    g    = r27[2];
    s    = |r27[1:0];
    up   = g & (s | m[0]);
    r    = {sb, expf, m[22:0]} + {31'd0, up};
    if (xnan || ynan) begin
      r = FP_QNAN;
    end else if (xinf && yinf) begin
      r = (x[31] != y[31]) ? FP_QNAN : x;
    end else if (xinf) begin
      r = x;
    end else if (yinf) begin
      r = y;
    end else if (sum == 28'd0) begin
      r = {x[31] & y[31], 31'd0};
    end else if (ee >= 9'd255) begin
      r = {sb, 8'hFF, 23'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] x, input logic [31:0] y);
    return fp_add(x, {~y[31], y[30:0]});
  endfunction

endpackage

[rtl/fvdu_front.sv]
// Front end: accepts input beats, holds the configuration registers and tags
// dot product elements by position. Depends on fvdu_pkg.
`timescale 1ns / 1ps

module fvdu_front
  import fvdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        q_full,
  output logic        push,
  output work_t       push_data,
  output logic        dot_clear
);

  logic [31:0]      scalar_factor;
  logic [LEN_W-1:0] vector_length;
  logic [LEN_W-1:0] element_position;
  logic [LEN_W-1:0] len_eff, full_len;
  logic             accept, is_dot;
  op_t              op;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_data.cmd);
  assign is_dot   = (op == OP_DOT);
  assign push     = accept && (in_data.cmd <= OP_BUTTERFLY);

  assign dot_clear = cfg_we && (cfg_index == CFG_VECTOR_LENGTH);

  assign len_eff  = (vector_length == '0) ? LEN_W'(1) : vector_length;
  assign full_len = {len_eff[LEN_W-1:LANE_W], {LANE_W{1'b0}}};

  always_comb begin
    push_data.op = op;
    push_data.a  = in_data.operand_a;
    push_data.b  = (op == OP_MUL_SCALAR || op == OP_MAC_SCALAR) ? scalar_factor
                                                                : in_data.operand_b;
    push_data.c  = in_data.addend;
    push_data.tag.lane      = element_position[LANE_W-1:0];
    push_data.tag.in_tail   = (element_position >= full_len);
    push_data.tag.last_full = (full_len != '0) && (element_position == full_len - LEN_W'(1));
    push_data.tag.is_last   = (element_position == len_eff - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_factor    <= '0;
      vector_length    <= LEN_W'(1);
      element_position <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_SCALAR_FACTOR) scalar_factor <= cfg_data;
      if (dot_clear) begin
        vector_length    <= cfg_data[LEN_W-1:0];
        element_position <= '0;
      end else if (accept && is_dot) begin
        element_position <= push_data.tag.is_last ? '0 : element_position + LEN_W'(1);
      end
    end
  end

endmodule

[rtl/fvdu_queue.sv]
// Short first-in first-out queue of classified work items between the
// front and back ends. Depends on fvdu_pkg.
`timescale 1ns / 1ps

module fvdu_queue
  import fvdu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output work_t data
);

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/fvdu_back.sv]
// Back end: multiply stage, add stage with the dot product lane sums and
// combine sequencer, and the output register. Depends on fvdu_pkg.
`timescale 1ns / 1ps

module fvdu_back
  import fvdu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      dot_clear,
  input  logic      q_valid,
  input  work_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_SUM01 = 4'b0010,
    ST_SUM2  = 4'b0100,
    ST_SUM3  = 4'b1000
  } comb_state_t;

  comb_state_t state, state_next;
  logic        s1_valid, s2_valid;
  work_t       s1_item, s2_item;
  logic [31:0] s1_prod, s2_prod;
  logic [31:0] lanes [LANES];
  logic [31:0] tail_sum;
  logic [31:0] add_x, add_y, sum, diff;
  logic        is_dot, need_out, fire, s2_leave, s2_load, out_free;
  out_item_t   result;

  assign is_dot   = (s2_item.op == OP_DOT);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    add_x      = s2_prod;
    add_y      = s2_item.c;
    need_out   = 1'b1;
    state_next = state;
    case (state)
      ST_RUN: begin
        if (s2_item.op == OP_BUTTERFLY) begin
          add_x = s2_item.a;
          add_y = s2_item.b;
        end else if (is_dot && s2_item.tag.in_tail) begin
          add_x    = tail_sum;
          add_y    = s2_prod;
          need_out = s2_item.tag.is_last;
        end else if (is_dot) begin
          add_x    = lanes[s2_item.tag.lane];
          add_y    = s2_prod;
          need_out = 1'b0;
          if (s2_item.tag.last_full) state_next = ST_SUM01;
        end
      end
      ST_SUM01: begin
        add_x      = lanes[0];
        add_y      = lanes[1];
        need_out   = 1'b0;
        state_next = ST_SUM2;
      end
      ST_SUM2: begin
        add_x      = tail_sum;
        add_y      = lanes[2];
        need_out   = 1'b0;
        state_next = ST_SUM3;
      end
      ST_SUM3: begin
        add_x      = tail_sum;
        add_y      = lanes[LANES-1];
        need_out   = s2_item.tag.is_last;
        state_next = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  assign sum  = fp_add(add_x, add_y);
  assign diff = fp_sub(s2_item.a, s2_item.b);

  assign fire     = s2_valid && (!need_out || out_free);
  assign s2_leave = fire && (state == ST_SUM3 ||
                    (state == ST_RUN && state_next == ST_RUN));
  assign s2_load  = s1_valid && (!s2_valid || s2_leave);
  assign q_pop    = q_valid && (!s1_valid || s2_load);

  always_comb begin
    result.first_result  = sum;
    result.second_result = FP_ZERO;
    result.is_dot_total  = 1'b0;
    case (s2_item.op)
      OP_MUL, OP_MUL_SCALAR: result.first_result = s2_prod;
      OP_BUTTERFLY:          result.second_result = diff;
      OP_DOT:                result.is_dot_total = 1'b1;
      default:               result.first_result = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item <= q_data;
      s1_prod <= fp_mul(q_data.a, q_data.b);
    end
    if (s2_load) begin
      s2_item <= s1_item;
      s2_prod <= s1_prod;
    end
    if (fire && need_out) out_data <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= ST_RUN;
    end else begin
      if (q_pop)         s1_valid <= 1'b1;
      else if (s2_load)  s1_valid <= 1'b0;
      if (s2_load)       s2_valid <= 1'b1;
      else if (s2_leave) s2_valid <= 1'b0;
      if (fire && need_out) out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
      if (fire) state <= state_next;
    end
  end

  // Dot product accumulators.
  always_ff @(posedge clk) begin
    if (rst || dot_clear) begin
      for (int i = 0; i < LANES; i++) lanes[i] <= FP_ZERO;
      tail_sum <= FP_ZERO;
    end else if (fire && is_dot) begin
      case (state)
        ST_RUN: begin
          if (s2_item.tag.in_tail) tail_sum <= s2_item.tag.is_last ? FP_ZERO : sum;
          else                     lanes[s2_item.tag.lane] <= sum;
        end
        ST_SUM01, ST_SUM2: tail_sum <= sum;
        ST_SUM3: begin
          for (int i = 0; i < LANES; i++) lanes[i] <= FP_ZERO;
          tail_sum <= s2_item.tag.is_last ? FP_ZERO : sum;
        end
        default: tail_sum <= tail_sum;
      endcase
    end
  end

endmodule

[rtl/float_vector_dsp_unit.sv]
// Top level of the single-precision vector multiply-accumulate unit.
// Depends on fvdu_pkg, fvdu_front, fvdu_queue and fvdu_back.
`timescale 1ns / 1ps
//
// Usage: one element enters per input beat (in_valid/in_ready, payload
// in_data) under a command: multiply, multiply by scalar, scalar
// multiply-accumulate, multiply-add, dot product element, or butterfly.
// Each result leaves as one output beat (out_valid/out_ready, out_data).
// Dot product elements give no beat except the last one of a vector,
// which carries the total with is_dot_total set. Commands 6 and 7 are
// accepted and dropped.
// The configuration port writes scalar_factor (index 0) or vector_length
// (index 1) whenever cfg_we is high; writing vector_length also restarts
// the dot product. Write it only while the unit is idle.
// A beat is registered in the queue, multiply stage, add stage and output
// register. Throughput is one beat per cycle while out_ready is high; the
// element completing the last full group of four in a dot product holds
// the add stage while the four lane sums are folded with the single adder.
// The front accepts while the four-entry queue has room, so a stalled
// receiver backs the queue up and in_ready falls only once it is full.
// Reset (rst, synchronous) empties the pipeline, sets scalar_factor to
// zero, vector_length to one and clears all dot product sums.

module float_vector_dsp_unit
  import fvdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic  push, q_full, q_valid, q_pop, dot_clear;
  work_t push_data, q_data;

  // Front end classifies beats and tags dot product positions.
  fvdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .dot_clear (dot_clear)
  );

  // The queue lets the front keep accepting while the back end stalls.
  fvdu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // Back end does the multiply, the add and the dot product accumulation.
  fvdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dot_clear (dot_clear),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[test/tb_float_vector_dsp_unit.sv]
// Self-checking testbench for float_vector_dsp_unit: directed table, then random phases.
// Depends on fvdu_pkg and the RTL of the unit; has its own bit-exact float predictor.
`timescale 1ns / 1ps

module tb_float_vector_dsp_unit;
  import fvdu_pkg::*;

  // Commands 6 and 7 are not operations; the unit must accept and drop them.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         STALL_LIMIT = 1000;
  localparam int         DIR_ROWS = 20;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  float_vector_dsp_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predictor state: a private copy of the registers and the dot product sums.
  logic [31:0] pred_scalar;
  logic [15:0] pred_length;
  logic [31:0] pred_lanes [4];
  logic [31:0] pred_tail;
  int unsigned pred_pos;

  out_item_t pending_outputs [$];
  int        mismatch_count;
  int        idle_cycles;
  bit        sink_calm;
  int        sink_hold;

  // Rounds m * 2^e (m nonzero) to single precision, nearest even.
  function automatic logic [31:0] sp_round(logic s, logic [89:0] m, int e);
    int          top, lsb, be, sh;
    logic [89:0] q;
    logic        g, st;
    logic [24:0] mant;
    top = 0;
    for (int i = 0; i < 90; i++) if (m[i]) top = i;
    lsb = top - 23 + e;
    be  = lsb + 150;
    if (be < 1) begin
      lsb = -149;
      be  = 1;
    end
    sh = lsb - e;
    if (sh > 89) begin
      q  = '0;
      g  = 1'b0;
      st = 1'b1;
    end else if (sh > 0) begin
      q  = m >> sh;
      g  = m[sh-1];
      st = |(m & ((90'd1 << (sh - 1)) - 90'd1));
    end else begin
      q  = m << (-sh);
      g  = 1'b0;
      st = 1'b0;
    end
    mant = q[24:0];
    if (g && (st || mant[0])) mant = mant + 25'd1;
    if (mant[24]) begin
      mant = mant >> 1;
      be   = be + 1;
    end
    if (be >= 255) return {s, 8'hFF, 23'd0};
    return {s, mant[23] ? 8'(be) : 8'd0, mant[22:0]};
  endfunction

  function automatic bit sp_is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic bit sp_is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] sp_multiply(logic [31:0] x, logic [31:0] y);
    logic s;
    int   ex, ey;
    s = x[31] ^ y[31];
    if (sp_is_nan(x) || sp_is_nan(y)) return FP_QNAN;
    if (sp_is_inf(x) || sp_is_inf(y)) begin
      if (x[30:0] == 31'd0 || y[30:0] == 31'd0) return FP_QNAN;
      return {s, 8'hFF, 23'd0};
    end
    if (x[30:0] == 31'd0 || y[30:0] == 31'd0) return {s, 31'd0};
    ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
    return sp_round(s, 90'({x[30:23] != 8'd0, x[22:0]}) * 90'({y[30:23] != 8'd0, y[22:0]}),
                    ex + ey - 300);
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] x, logic [31:0] y);
    logic [31:0] big, lit;
    int          e1, e2, d, base;
    logic [89:0] ma, mb, res;
    logic        rs;
    if (sp_is_nan(x) || sp_is_nan(y)) return FP_QNAN;
    if (sp_is_inf(x) && sp_is_inf(y)) return (x[31] != y[31]) ? FP_QNAN : x;
    if (sp_is_inf(x)) return x;
    if (sp_is_inf(y)) return y;
    if (x[30:0] == 31'd0 && y[30:0] == 31'd0) return {x[31] & y[31], 31'd0};
    if (x[30:23] >= y[30:23]) begin
      big = x;
      lit = y;
    end else begin
      big = y;
      lit = x;
    end
    e1 = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
    e2 = (lit[30:23] == 8'd0) ? 1 : int'(lit[30:23]);
    d  = e1 - e2;
    ma = 90'({big[30:23] != 8'd0, big[22:0]});
    mb = 90'({lit[30:23] != 8'd0, lit[22:0]});
    // Far below the larger operand, the smaller one only matters as a sticky bit.
    if (d > 60) begin
      ma   = ma << 60;
      mb   = (mb != '0) ? 90'd1 : 90'd0;
      base = e1 - 210;
    end else begin
      ma   = ma << d;
      base = e2 - 150;
    end
    if (big[31] == lit[31]) begin
      res = ma + mb;
      rs  = big[31];
    end else if (ma >= mb) begin
      res = ma - mb;
      rs  = big[31];
    end else begin
      res = mb - ma;
      rs  = lit[31];
    end
    if (res == '0) return FP_ZERO;
    return sp_round(rs, res, base);
  endfunction

  function automatic logic [31:0] sp_canon(logic [31:0] x);
    return sp_is_nan(x) ? FP_QNAN : x;
  endfunction

  task automatic clear_dot_state();
    for (int i = 0; i < 4; i++) pred_lanes[i] = FP_ZERO;
    pred_tail = FP_ZERO;
    pred_pos  = 0;
  endtask

  // Works out what one accepted beat produces and advances the dot product state.
  task automatic compute_dsp_result(input in_item_t it, output bit got, output out_item_t r);
    int unsigned len, full;
    logic [31:0] prod, s;
    r   = '0;
    got = 1'b1;
    case (it.cmd)
      OP_MUL:        r.first_result = sp_multiply(it.operand_a, it.operand_b);
      OP_MUL_SCALAR: r.first_result = sp_multiply(it.operand_a, pred_scalar);
      OP_MAC_SCALAR: r.first_result = sp_add(it.addend, sp_multiply(it.operand_a, pred_scalar));
      OP_MUL_ADD:    r.first_result = sp_add(sp_multiply(it.operand_a, it.operand_b), it.addend);
      OP_BUTTERFLY: begin
        r.first_result  = sp_add(it.operand_a, it.operand_b);
        r.second_result = sp_add(it.operand_a, {~it.operand_b[31], it.operand_b[30:0]});
      end
      OP_DOT: begin
        len  = (pred_length == 16'd0) ? 1 : pred_length;
        full = len & ~32'd3;
        prod = sp_multiply(it.operand_a, it.operand_b);
        if (pred_pos < full) begin
          pred_lanes[pred_pos % 4] = sp_add(pred_lanes[pred_pos % 4], prod);
          if (pred_pos == full - 1) begin
            // The last full group folds the lanes in a fixed order.
            s         = sp_add(pred_lanes[0], pred_lanes[1]);
            s         = sp_add(s, pred_lanes[2]);
            pred_tail = sp_add(s, pred_lanes[3]);
            for (int i = 0; i < 4; i++) pred_lanes[i] = FP_ZERO;
          end
        end else begin
          pred_tail = sp_add(pred_tail, prod);
        end
        if (pred_pos + 1 >= len) begin
          r.first_result = pred_tail;
          r.is_dot_total = 1'b1;
          clear_dot_state();
        end else begin
          pred_pos = pred_pos + 1;
          got      = 1'b0;
        end
      end
      default: got = 1'b0;
    endcase
    r.first_result  = sp_canon(r.first_result);
    r.second_result = sp_canon(r.second_result);
  endtask

  // Output side: every beat is checked against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected output beat: %h %h %b", out_data.first_result,
                   out_data.second_result, out_data.is_dot_total);
      end else begin
        want = pending_outputs.pop_front();
        if (want.first_result !== out_data.first_result ||
            want.second_result !== out_data.second_result ||
            want.is_dot_total !== out_data.is_dot_total) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("output mismatch: expected %h %h %b, got %h %h %b",
                     want.first_result, want.second_result, want.is_dot_total,
                     out_data.first_result, out_data.second_result, out_data.is_dot_total);
        end
      end
    end
  end

  // The receiver stalls in random bursts, except while sink_calm holds it open.
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_calm) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_ready <= 1'b1;
      end else if (r < 93) begin
        out_ready <= 1'b0;
        sink_hold <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        sink_hold <= $urandom_range(5, 30);
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either side means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap: mostly back to back, sometimes short, rarely long.
  function automatic int sender_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Presents one beat, waits for it to be taken, then idles for a random gap.
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t typed_out,
                           input bit calm);
    bit        got;
    out_item_t r;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    compute_dsp_result(it, got, r);
    if (typed) r = typed_out;
    if (got || typed) pending_outputs.push_back(r);
    gap = sender_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    // A dot element with no result may still be in flight.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCALAR_FACTOR) begin
      pred_scalar = value;
    end else begin
      pred_length = value[15:0];
      clear_dot_state();
    end
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] specials [12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
      32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000};
    case ($urandom_range(0, 9))
      0: return specials[$urandom_range(0, 11)];
      1: return $urandom;
      2: return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
    endcase
  endfunction

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  // Directed rows run with the reset configuration: scalar zero, length one.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_MUL, 32'h3F80_0000, 32'h4000_0000, 32'h0, 1'b1, '{32'h4000_0000, 32'h0, 1'b0}},
    '{OP_MUL, 32'h7FFF_FFFF, 32'h3F80_0000, 32'h0, 1'b1, '{FP_QNAN, 32'h0, 1'b0}},
    '{OP_MUL, 32'h7F80_0000, 32'h0000_0000, 32'h0, 1'b1, '{FP_QNAN, 32'h0, 1'b0}},
    '{OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000, 32'h0, 1'b1, '{32'h7F80_0000, 32'h0, 1'b0}},
    '{OP_MUL, 32'h0000_0001, 32'h3F00_0000, 32'h0, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{OP_MUL_SCALAR, 32'h40A0_0000, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
    '{OP_MAC_SCALAR, 32'hFFFF_FFFF, 32'h0, 32'h3F80_0000, 1'b1, '{FP_QNAN, 32'h0, 1'b0}},
    '{OP_MUL_ADD, 32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 1'b1,
      '{32'h0, 32'h0, 1'b0}},
    '{OP_MUL_ADD, 32'h8000_0001, 32'h7F7F_FFFF, 32'h0080_0000, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{OP_DOT, 32'h4000_0000, 32'h4040_0000, 32'h0, 1'b1, '{32'h40C0_0000, 32'h0, 1'b1}},
    '{OP_DOT, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{OP_BUTTERFLY, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 1'b1,
      '{32'h4000_0000, 32'h0, 1'b0}},
    '{OP_BUTTERFLY, 32'h7F80_0000, 32'h7F80_0000, 32'h0, 1'b1,
      '{32'h7F80_0000, FP_QNAN, 1'b0}},
    '{OP_BUTTERFLY, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 1'b1,
      '{32'h7F80_0000, 32'h0, 1'b0}},
    '{CMD_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{CMD_SPARE7, 32'h0, 32'h0, 32'h0, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{OP_BUTTERFLY, 32'h8000_0000, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, 32'h0, 1'b0}},
    '{OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, '{FP_QNAN, 32'h0, 1'b0}},
    '{OP_MAC_SCALAR, 32'h3F80_0000, 32'h0, 32'h3F80_0000, 1'b1,
      '{32'h3F80_0000, 32'h0, 1'b0}},
    '{OP_DOT, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0, 1'b1, '{32'hFF80_0000, 32'h0, 1'b1}}
  };

  typedef struct {
    logic [31:0] scalar;
    logic [31:0] length;
    int          beats;
    bit          dot_heavy;
  } phase_t;

  // Each phase reconfigures the unit; lengths cover zero, one, the maximum and
  // sizes with and without a tail after the last full group.
  phase_t phases [10] = '{
    '{32'h3FC0_0000, 32'd4, 160, 1'b1},
    '{32'h0000_0000, 32'd0, 150, 1'b0},
    '{32'h7F7F_FFFF, 32'd5, 200, 1'b1},
    '{32'hFFFF_FFFF, 32'd65535, 40, 1'b1},
    '{32'h0000_0001, 32'd7, 180, 1'b1},
    '{32'hBF80_0000, 32'd8, 180, 1'b1},
    '{32'h4049_0FDB, 32'd1, 180, 1'b0},
    '{32'h8000_0000, 32'd3, 180, 1'b1},
    '{32'h3E4C_CCCD, 32'd13, 200, 1'b1},
    '{32'h7F80_0000, 32'd2, 200, 1'b1}
  };

  initial begin
    in_item_t  it;
    out_item_t none;
    bit        calm;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SCALAR_FACTOR;
    cfg_data       = '0;
    sink_calm      = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    none           = '0;
    pred_scalar    = FP_ZERO;
    pred_length    = 16'd1;
    clear_dot_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it = '{dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b, dir_rows[i].c};
      send_beat(it, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    end

    foreach (phases[p]) begin
      drain_outputs();
      write_register(CFG_SCALAR_FACTOR, phases[p].scalar);
      write_register(CFG_VECTOR_LENGTH, phases[p].length);
      // Some phases run with neither side idling at all.
      calm      = (p % 3 == 1);
      sink_calm = calm;
      for (int n = 0; n < phases[p].beats; n++) begin
        if (phases[p].dot_heavy && $urandom_range(0, 99) < 75)
          it.cmd = OP_DOT;
        else
          it.cmd = 3'($urandom_range(0, 7));
        it.operand_a = random_float();
        case ($urandom_range(0, 7))
          0: it.operand_b = it.operand_a;
          1: it.operand_b = {~it.operand_a[31], it.operand_a[30:0]};
          default: it.operand_b = random_float();
        endcase
        it.addend = random_float();
        send_beat(it, 1'b0, none, calm);
        // Once, the sender holds off until every expected result is back.
        if (p == 4 && n == 90) begin
          in_valid <= 1'b0;
          while (pending_outputs.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid  <= 1'b0;
    sink_calm <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
